// ----- hw/rtl/e2c_pkg.sv -----
// Shared types, constants and the month length table for the epoch-to-calendar block.
`timescale 1ns / 1ps
package e2c_pkg;

  localparam int unsigned InW      = 32;
  localparam int unsigned DaysW    = 16;  // whole days since 1970 fit in 16 bits
  localparam int unsigned TodW     = 17;  // seconds of the day, below 86400

  localparam logic [TodW-1:0] SecsPerHour = 17'd3600;
  localparam logic [TodW-1:0] SecsPerMin  = 17'd60;

  // 86400 = 675 << 7: days = (secs >> 7) * ceil(2^35 / 675) >> 35, exact for 25 bits
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [9:0]  DayOdd    = 10'd675;
  // 3600 = 225 << 4: ceil(2^21 / 225), exact below 5400
  localparam logic [13:0] HourRecip = 14'd9321;
  // 60 = 15 << 2: ceil(2^14 / 15), exact below 900
  localparam logic [10:0] MinRecip  = 11'd1093;

  localparam logic [11:0] BaseYear    = 12'd1970;
  localparam logic [6:0]  BaseMod100  = 7'd70;
  localparam logic [8:0]  BaseMod400  = 9'd370;
  localparam logic [8:0]  DaysInYear  = 9'd365;
  localparam logic [8:0]  DaysInLeap  = 9'd366;
  localparam logic [3:0]  LastMonth   = 4'd11;
  // 1970-01-01 was a Thursday; Monday is weekday 1
  localparam logic [3:0]  EpochWdOfs  = 4'd3;

  typedef struct packed {
    logic load;
    logic day_step;
    logic tod_step;
    logic hour_step;
    logic min_step;
    logic year_step;
    logic month_step;
  } cmd_t;

  typedef struct packed {
    logic year_fit;
    logic month_fit;
  } sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/epoch_seconds_to_calendar_top.sv -----
// Top level: epoch seconds to Gregorian date, time of day and weekday.
//
//  channel   handshake             beat contents
//  command   start / busy          epoch_seconds_i
//  result    valid_o (one cycle)   year_o month_o day_of_month_o hour_o
//                                  minute_o second_o weekday_o
//
// One beat steps through the day count by reciprocal multiply, the seconds of day
// and weekday, the hour split and the minute split, then subtracts one year per step
// (up to 136 years) until the days fit, one month per step (up to 11 months), and
// ends in a result cycle. Reset clears only the controller; busy stays high from accept
// until the result cycle ends. Results are shown for exactly one cycle; the receiver
// cannot stall them.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_top import e2c_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic [InW-1:0] epoch_seconds_i,
  output logic           valid_o,
  output logic [11:0]    year_o,
  output logic [3:0]     month_o,
  output logic [4:0]     day_of_month_o,
  output logic [4:0]     hour_o,
  output logic [5:0]     minute_o,
  output logic [5:0]     second_o,
  output logic [2:0]     weekday_o
);

  cmd_t cmd;
  sts_t sts;

  e2c_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  e2c_dp u_dp (
    .clk_i           (clk_i),
    .epoch_seconds_i (epoch_seconds_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o),
    .weekday_o       (weekday_o)
  );

endmodule

// ----- hw/rtl/e2c_dp.sv -----
// Datapath: day count by reciprocal multiply, time-of-day split, year and month subtraction.
`timescale 1ns / 1ps
module e2c_dp import e2c_pkg::*; (
  input  logic            clk_i,
  input  logic [InW-1:0]  epoch_seconds_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output logic [11:0]     year_o,
  output logic [3:0]      month_o,
  output logic [4:0]      day_of_month_o,
  output logic [4:0]      hour_o,
  output logic [5:0]      minute_o,
  output logic [5:0]      second_o,
  output logic [2:0]      weekday_o
);

  logic [InW-1:0]   sec_q, sec_d;
  // day count, then day of year, then day of month
  logic [DaysW-1:0] quot_q, quot_d;
  // seconds of the day, then of the hour, then of the minute
  logic [TodW-1:0]  tod_q, tod_d;
  logic [2:0]       w7_q, w7_d;     // day count mod 7
  logic [11:0]      year_q, year_d;
  logic [6:0]       m100_q, m100_d;
  logic [8:0]       m400_q, m400_d;
  logic [3:0]       mon_q, mon_d;
  logic [4:0]       hour_q, hour_d;
  logic [5:0]       min_q, min_d;

  logic [50:0]      day_prod;
  logic [24:0]      day_base;
  logic [24:0]      day_rem;
  logic [5:0]       oct_sum;
  logic [3:0]       oct_fold;
  logic [25:0]      hour_prod;
  logic [4:0]       hour_quo;
  logic [19:0]      min_prod;
  logic [5:0]       min_quo;
  logic             leap;
  logic [8:0]       ylen;
  logic [4:0]       mlen;
  logic [3:0]       wd_sum;

  assign day_prod = 51'(sec_q[InW-1:7]) * 51'(DayRecip);
  assign day_base = 25'(quot_q) * 25'(DayOdd);
  assign day_rem  = sec_q[InW-1:7] - day_base;

  // 8 is 1 mod 7, so the octal digits sum to the same residue
  assign oct_sum  = {3'd0, quot_q[2:0]} + {3'd0, quot_q[5:3]} + {3'd0, quot_q[8:6]}
                  + {3'd0, quot_q[11:9]} + {3'd0, quot_q[14:12]} + {5'd0, quot_q[15]};
  assign oct_fold = {1'b0, oct_sum[2:0]} + {1'b0, oct_sum[5:3]};

  assign hour_prod = 26'(tod_q[TodW-1:4]) * 26'(HourRecip);
  assign hour_quo  = hour_prod[25:21];
  assign min_prod  = 20'(tod_q[11:2]) * 20'(MinRecip);
  assign min_quo   = min_prod[19:14];

  assign leap = (year_q[1:0] == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
  assign ylen = leap ? DaysInLeap : DaysInYear;
  assign mlen = month_len(mon_q, leap);

  assign sts_o.year_fit  = ({7'd0, quot_q[8:0]} < {7'd0, ylen}) && (quot_q[DaysW-1:9] == '0);
  assign sts_o.month_fit = (mon_q == LastMonth) || (quot_q < {11'd0, mlen});

  always_comb begin
    sec_d  = sec_q;
    quot_d = quot_q;
    tod_d  = tod_q;
    w7_d   = w7_q;
    year_d = year_q;
    m100_d = m100_q;
    m400_d = m400_q;
    mon_d  = mon_q;
    hour_d = hour_q;
    min_d  = min_q;
    if (cmd_i.load) begin
      sec_d  = epoch_seconds_i;
      year_d = BaseYear;
      m100_d = BaseMod100;
      m400_d = BaseMod400;
      mon_d  = 4'd0;
    end else begin
      if (cmd_i.day_step) begin
        quot_d = day_prod[50:35];
      end
      if (cmd_i.tod_step) begin
        tod_d = {day_rem[9:0], sec_q[6:0]};
        w7_d  = (oct_fold >= 4'd7) ? 3'(oct_fold - 4'd7) : oct_fold[2:0];
      end
      if (cmd_i.hour_step) begin
        hour_d = hour_quo;
        tod_d  = tod_q - TodW'(hour_quo) * SecsPerHour;
      end
      if (cmd_i.min_step) begin
        min_d = min_quo;
        tod_d = tod_q - TodW'(min_quo) * SecsPerMin;
      end
      if (cmd_i.year_step) begin
        quot_d = quot_q - {7'd0, ylen};
        year_d = year_q + 12'd1;
        m100_d = (m100_q == 7'd99)  ? 7'd0 : m100_q + 7'd1;
        m400_d = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
      end
      if (cmd_i.month_step) begin
        quot_d = quot_q - {11'd0, mlen};
        mon_d  = mon_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec_d;
    quot_q <= quot_d;
    tod_q  <= tod_d;
    w7_q   <= w7_d;
    year_q <= year_d;
    m100_q <= m100_d;
    m400_q <= m400_d;
    mon_q  <= mon_d;
    hour_q <= hour_d;
    min_q  <= min_d;
  end

  assign wd_sum = {1'b0, w7_q} + EpochWdOfs;

  assign year_o         = year_q;
  assign month_o        = mon_q + 4'd1;
  assign day_of_month_o = quot_q[4:0] + 5'd1;
  assign hour_o         = hour_q;
  assign minute_o       = min_q;
  assign second_o       = tod_q[5:0];
  assign weekday_o      = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd6) : 3'(wd_sum + 4'd1);

endmodule

// ----- hw/rtl/e2c_ctrl.sv -----
// Controller: sequences the day count, time-of-day, year and month steps.
`timescale 1ns / 1ps
module e2c_ctrl import e2c_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DAY   = 8'b00000010,
    S_TOD   = 8'b00000100,
    S_HOUR  = 8'b00001000,
    S_MIN   = 8'b00010000,
    S_YEAR  = 8'b00100000,
    S_MONTH = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DAY;
        end
      end
      S_DAY: begin
        cmd_o.day_step = 1'b1;
        state_d        = S_TOD;
      end
      S_TOD: begin
        cmd_o.tod_step = 1'b1;
        state_d        = S_HOUR;
      end
      S_HOUR: begin
        cmd_o.hour_step = 1'b1;
        state_d         = S_MIN;
      end
      S_MIN: begin
        cmd_o.min_step = 1'b1;
        state_d        = S_YEAR;
      end
      S_YEAR: begin
        if (sts_i.year_fit) begin
          state_d = S_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (sts_i.month_fit) begin
          state_d = S_DONE;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);

endmodule
